>>> sv/rqtr_pkg.sv
// Shared constants and codes for the quarter-turn raster rotator.
package rqtr_pkg;

    localparam int PIXEL_W     = 32;
    localparam int CFG_W       = 9;
    localparam int CFG_IDX_W   = 2;

    localparam int DEF_MAX_ROWS    = 256;
    localparam int DEF_MAX_COLS    = 256;
    localparam int DEF_PIXEL_BYTES = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUARTER_TURNS = 2'd2;

    localparam logic [1:0] TURN_NONE  = 2'd0;
    localparam logic [1:0] TURN_LEFT  = 2'd1;
    localparam logic [1:0] TURN_HALF  = 2'd2;
    localparam logic [1:0] TURN_RIGHT = 2'd3;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic [CFG_W-1:0] RST_NUM_ROWS = 9'd1;
    localparam logic [CFG_W-1:0] RST_NUM_COLS = 9'd1;
    localparam logic [1:0]       RST_TURNS    = TURN_NONE;

endpackage

>>> sv/rqtr_ram.sv
// Generic simple dual-port RAM with registered read data.
module rqtr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/raster_quarter_turn_rotator_unit.sv
// Top level of the quarter-turn raster rotator: frame store, load and rotated read walk.
// A load transfer writes the frame store at its accept edge; a read transfer's pixel is
// registered and shows with o_valid in the next cycle; the receiver cannot stall.
// Throughput: one transfer per cycle while busy is low, set by the single write and
// single read port of the frame store; busy is high in reset and clears after it.
// Reset zeroes positions and sets 1x1, no turn, busy; frame store undefined until loaded.
module raster_quarter_turn_rotator_unit #(
    parameter int MAX_ROWS    = rqtr_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS    = rqtr_pkg::DEF_MAX_COLS,
    parameter int PIXEL_BYTES = rqtr_pkg::DEF_PIXEL_BYTES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_kind,
    input  logic [rqtr_pkg::PIXEL_W-1:0]    i_pixel,
    output logic                            o_valid,
    output logic [rqtr_pkg::PIXEL_W-1:0]    o_pixel_out,
    output logic                            o_last,
    input  logic                            i_cfg_we,
    input  logic [rqtr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rqtr_pkg::CFG_W-1:0]      i_cfg_data
);

    localparam int MAXD  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int DW    = $clog2(MAXD + 1);
    localparam int IW    = (MAXD > 1) ? $clog2(MAXD) : 1;
    localparam int PW    = 2 * DW;
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW    = $clog2(DEPTH + 1);
    localparam int SB    = (PIXEL_BYTES < 4) ? PIXEL_BYTES : 4;
    localparam int SW    = 8 * SB;
    localparam int CW    = (DW > rqtr_pkg::CFG_W) ? DW : rqtr_pkg::CFG_W;

    logic [rqtr_pkg::CFG_W-1:0] r_num_rows;
    logic [rqtr_pkg::CFG_W-1:0] r_num_cols;
    logic [1:0]                 r_turns;
    logic [LW-1:0]              r_load_index;
    logic [IW-1:0]              r_out_row;
    logic [IW-1:0]              r_out_col;
    logic                       r_valid;
    logic                       r_last;
    logic                       r_busy;

    logic [LW-1:0] n_load_index;
    logic [IW-1:0] n_out_row;
    logic [IW-1:0] n_out_col;
    logic          n_last;

    logic          w_accept;
    logic          w_load;
    logic          w_read;
    logic [DW-1:0] w_rows;
    logic [DW-1:0] w_cols;
    logic [PW-1:0] w_size;
    logic [LW-1:0] w_load_idx;
    logic [PW-1:0] w_load_inc;
    logic          w_odd;
    logic [DW-1:0] w_orows;
    logic [DW-1:0] w_ocols;
    logic [IW-1:0] w_row;
    logic [IW-1:0] w_col;
    logic [DW-1:0] w_row_d;
    logic [DW-1:0] w_col_d;
    logic [DW-1:0] w_si;
    logic [DW-1:0] w_sj;
    logic [PW-1:0] w_src;
    logic [SW-1:0] w_rdata;

    assign w_accept = start && !busy;
    assign w_load   = w_accept && (i_kind == rqtr_pkg::KIND_LOAD);
    assign w_read   = w_accept && (i_kind == rqtr_pkg::KIND_READ);

    // saturate dimensions into 1..MAX
    always_comb begin
        if (r_num_rows == '0) begin
            w_rows = DW'(1);
        end else if (CW'(r_num_rows) > CW'(MAX_ROWS)) begin
            w_rows = DW'(MAX_ROWS);
        end else begin
            w_rows = DW'(r_num_rows);
        end
        if (r_num_cols == '0) begin
            w_cols = DW'(1);
        end else if (CW'(r_num_cols) > CW'(MAX_COLS)) begin
            w_cols = DW'(MAX_COLS);
        end else begin
            w_cols = DW'(r_num_cols);
        end
    end

    assign w_size = PW'(w_rows) * PW'(w_cols);

    // load position: restart at zero when beyond the frame, wrap after the final pixel
    always_comb begin
        w_load_idx   = (PW'(r_load_index) < w_size) ? r_load_index : '0;
        w_load_inc   = PW'(w_load_idx) + PW'(1);
        n_load_index = (w_load_inc >= w_size) ? '0 : LW'(w_load_inc);
    end

    // rotated read walk
    assign w_odd   = (r_turns == rqtr_pkg::TURN_LEFT) || (r_turns == rqtr_pkg::TURN_RIGHT);
    assign w_orows = w_odd ? w_cols : w_rows;
    assign w_ocols = w_odd ? w_rows : w_cols;

    always_comb begin
        if ((DW'(r_out_row) >= w_orows) || (DW'(r_out_col) >= w_ocols)) begin
            w_row = '0;
            w_col = '0;
        end else begin
            w_row = r_out_row;
            w_col = r_out_col;
        end
        w_row_d = DW'(w_row);
        w_col_d = DW'(w_col);

        case (r_turns)
            rqtr_pkg::TURN_LEFT: begin
                w_si = w_rows - DW'(1) - w_col_d;
                w_sj = w_row_d;
            end
            rqtr_pkg::TURN_HALF: begin
                w_si = w_rows - DW'(1) - w_row_d;
                w_sj = w_cols - DW'(1) - w_col_d;
            end
            rqtr_pkg::TURN_RIGHT: begin
                w_si = w_col_d;
                w_sj = w_cols - DW'(1) - w_row_d;
            end
            default: begin
                w_si = w_row_d;
                w_sj = w_col_d;
            end
        endcase

        w_src  = PW'(w_si) * PW'(w_cols) + PW'(w_sj);
        n_last = (w_row_d == w_orows - DW'(1)) && (w_col_d == w_ocols - DW'(1));

        if (w_col_d + DW'(1) < w_ocols) begin
            n_out_col = IW'(w_col_d + DW'(1));
            n_out_row = w_row;
        end else begin
            n_out_col = '0;
            n_out_row = (w_row_d + DW'(1) < w_orows) ? IW'(w_row_d + DW'(1)) : '0;
        end
    end

    rqtr_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (AW'(w_load_idx)),
        .i_wdata (i_pixel[SW-1:0]),
        .i_re    (w_read),
        .i_raddr (AW'(w_src)),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows   <= rqtr_pkg::RST_NUM_ROWS;
            r_num_cols   <= rqtr_pkg::RST_NUM_COLS;
            r_turns      <= rqtr_pkg::RST_TURNS;
            r_load_index <= '0;
            r_out_row    <= '0;
            r_out_col    <= '0;
            r_valid      <= 1'b0;
            r_last       <= 1'b0;
            r_busy       <= 1'b1;
        end else begin
            r_busy  <= 1'b0;
            r_valid <= w_read;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    rqtr_pkg::CFG_NUM_ROWS:      r_num_rows <= i_cfg_data;
                    rqtr_pkg::CFG_NUM_COLS:      r_num_cols <= i_cfg_data;
                    rqtr_pkg::CFG_QUARTER_TURNS: r_turns    <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (w_load) begin
                r_load_index <= n_load_index;
            end
            if (w_read) begin
                r_out_row <= n_out_row;
                r_out_col <= n_out_col;
                r_last    <= n_last;
            end
        end
    end

    assign busy        = r_busy;
    assign o_valid     = r_valid;
    assign o_last      = r_last;
    assign o_pixel_out = rqtr_pkg::PIXEL_W'(w_rdata);

endmodule
